// ===== hdl/mpd_pkg.sv =====
package mpd_pkg;

  // Parse phase of the front end
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_STUFF = 2'd3
  } phase_t;

  // Start code values and masks
  localparam logic [23:0] SYNC_ONES   = 24'hFFFFFF;
  localparam logic [23:0] SYNC_PREFIX = 24'h000001;
  localparam logic [7:0]  CODE_END    = 8'hB9;
  localparam logic [7:0]  CODE_PACK   = 8'hBA;
  localparam logic [7:0]  MPEG2_MASK  = 8'hC0;
  localparam logic [7:0]  MPEG2_MARK  = 8'h40;
  localparam logic [7:0]  MPEG1_MASK  = 8'hF0;
  localparam logic [7:0]  MPEG1_MARK  = 8'h20;
  localparam logic [15:0] PACK2_BODY  = 16'd8;
  localparam logic [15:0] PACK1_BODY  = 16'd6;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One queued request: either a single byte or a whole start code
  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       last;
    logic       err;
    logic [7:0] code;
  } entry_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== hdl/mpd_front.sv =====
module mpd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  mpd_pkg::qstat_t   qstat,
  output logic              push,
  output mpd_pkg::entry_t   push_entry
);

  logic [23:0]          sync_window, sync_window_next;
  mpd_pkg::phase_t      phase, phase_next;
  logic                 second, second_next;
  logic [15:0]          bytes_left, bytes_left_next;
  logic [7:0]           current_code, current_code_next;
  logic                 mpeg2, mpeg2_next;
  logic [2:0]           stuffing_left, stuffing_left_next;
  logic                 accept;
  logic                 emit;
  logic [15:0]          bl_dec;
  logic [15:0]          bl_len;
  logic                 mpeg2_len;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;
  assign push     = accept && emit;
  assign bl_dec   = bytes_left - 16'd1;

  // Body length seen at the second length byte
  always_comb begin
    mpeg2_len = mpeg2;
    if (current_code == mpd_pkg::CODE_PACK) begin
      bl_len = mpeg2_len ? mpd_pkg::PACK2_BODY : mpd_pkg::PACK1_BODY;
    end else begin
      bl_len = {bytes_left[15:8], in_byte};
    end
  end

  // Parse one byte: next state
  always_comb begin
    sync_window_next   = sync_window;
    phase_next         = phase;
    second_next        = second;
    bytes_left_next    = bytes_left;
    current_code_next  = current_code;
    mpeg2_next         = mpeg2;
    stuffing_left_next = stuffing_left;
    case (phase)
      mpd_pkg::PH_LEN: begin
        if (!second) begin
          second_next = 1'b1;
          if (current_code == mpd_pkg::CODE_PACK) begin
            if ((in_byte & mpd_pkg::MPEG2_MASK) == mpd_pkg::MPEG2_MARK) begin
              mpeg2_next = 1'b1;
            end else if ((in_byte & mpd_pkg::MPEG1_MASK) == mpd_pkg::MPEG1_MARK) begin
              mpeg2_next = 1'b0;
            end else begin
              phase_next       = mpd_pkg::PH_HUNT;
              sync_window_next = mpd_pkg::SYNC_ONES;
              second_next      = 1'b0;
              bytes_left_next  = '0;
            end
          end else begin
            bytes_left_next = {in_byte, 8'd0};
          end
        end else begin
          second_next = 1'b0;
          if (bl_len == 16'd0) begin
            phase_next       = mpd_pkg::PH_HUNT;
            sync_window_next = mpd_pkg::SYNC_ONES;
            bytes_left_next  = '0;
          end else begin
            phase_next      = mpd_pkg::PH_BODY;
            bytes_left_next = bl_len;
          end
        end
      end
      mpd_pkg::PH_BODY: begin
        bytes_left_next = bl_dec;
        if (bl_dec == 16'd0) begin
          phase_next       = mpd_pkg::PH_HUNT;
          sync_window_next = mpd_pkg::SYNC_ONES;
          if (current_code == mpd_pkg::CODE_PACK && mpeg2 && in_byte[2:0] != 3'd0) begin
            phase_next         = mpd_pkg::PH_STUFF;
            stuffing_left_next = in_byte[2:0];
          end
        end
      end
      mpd_pkg::PH_STUFF: begin
        stuffing_left_next = stuffing_left - 3'd1;
        if (stuffing_left == 3'd1) begin
          phase_next       = mpd_pkg::PH_HUNT;
          sync_window_next = mpd_pkg::SYNC_ONES;
        end
      end
      default: begin
        if (sync_window == mpd_pkg::SYNC_PREFIX) begin
          current_code_next = in_byte;
          sync_window_next  = mpd_pkg::SYNC_ONES;
          bytes_left_next   = '0;
          if (in_byte != mpd_pkg::CODE_END) begin
            phase_next  = mpd_pkg::PH_LEN;
            second_next = 1'b0;
          end
        end else begin
          sync_window_next = {sync_window[15:0], in_byte};
        end
      end
    endcase
  end

  // Parse one byte: queued request
  always_comb begin
    emit             = 1'b0;
    push_entry.start = 1'b0;
    push_entry.data  = in_byte;
    push_entry.last  = 1'b0;
    push_entry.err   = 1'b0;
    push_entry.code  = current_code;
    case (phase)
      mpd_pkg::PH_LEN: begin
        emit = 1'b1;
        if (!second) begin
          if (current_code == mpd_pkg::CODE_PACK
              && (in_byte & mpd_pkg::MPEG2_MASK) != mpd_pkg::MPEG2_MARK
              && (in_byte & mpd_pkg::MPEG1_MASK) != mpd_pkg::MPEG1_MARK) begin
            push_entry.last = 1'b1;
            push_entry.err  = 1'b1;
          end
        end else begin
          push_entry.last = (bl_len == 16'd0);
        end
      end
      mpd_pkg::PH_BODY: begin
        emit            = 1'b1;
        push_entry.last = (bl_dec == 16'd0);
      end
      mpd_pkg::PH_STUFF: begin
        emit = 1'b0;
      end
      default: begin
        if (sync_window == mpd_pkg::SYNC_PREFIX) begin
          emit             = 1'b1;
          push_entry.start = 1'b1;
          push_entry.code  = in_byte;
          push_entry.last  = (in_byte == mpd_pkg::CODE_END);
        end
      end
    endcase
  end

  // Advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_window   <= mpd_pkg::SYNC_ONES;
      phase         <= mpd_pkg::PH_HUNT;
      second        <= 1'b0;
      bytes_left    <= '0;
      current_code  <= '0;
      mpeg2         <= 1'b0;
      stuffing_left <= '0;
    end else if (accept) begin
      sync_window   <= sync_window_next;
      phase         <= phase_next;
      second        <= second_next;
      bytes_left    <= bytes_left_next;
      current_code  <= current_code_next;
      mpeg2         <= mpeg2_next;
      stuffing_left <= stuffing_left_next;
    end
  end

endmodule

// ===== hdl/mpd_fifo.sv =====
module mpd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mpd_pkg::entry_t   push_entry,
  input  logic              pop,
  output mpd_pkg::entry_t   head,
  output mpd_pkg::qstat_t   qstat
);

  mpd_pkg::entry_t          slots [mpd_pkg::QDEPTH];
  logic [mpd_pkg::QAW-1:0]  wr_ptr;
  logic [mpd_pkg::QAW-1:0]  rd_ptr;
  logic [mpd_pkg::QAW:0]    count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == (mpd_pkg::QAW+1)'(mpd_pkg::QDEPTH));
  assign qstat.empty = (count == '0);

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/mpd_back.sv =====
module mpd_back (
  input  logic              clk,
  input  logic              rst,
  input  mpd_pkg::entry_t   head,
  input  mpd_pkg::qstat_t   qstat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              first,
  output logic              last,
  output logic [7:0]        stream_code,
  output logic              error
);

  logic [1:0] beat;
  logic       load;
  logic       take;
  logic [7:0] byte_next;
  logic       first_next;
  logic       last_next;

  assign load = !out_valid || !out_stall;
  assign take = load && !qstat.empty;
  assign pop  = take && (!head.start || beat == 2'd3);

  // Pick the beat of a start code or pass a single byte
  always_comb begin
    byte_next  = head.data;
    first_next = 1'b0;
    last_next  = head.last;
    if (head.start) begin
      case (beat)
        2'd0: begin
          byte_next  = 8'h00;
          first_next = 1'b1;
          last_next  = 1'b0;
        end
        2'd1: begin
          byte_next = 8'h00;
          last_next = 1'b0;
        end
        2'd2: begin
          byte_next = 8'h01;
          last_next = 1'b0;
        end
        default: begin
          byte_next = head.data;
        end
      endcase
    end
  end

  // Hold output valid and beat count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= '0;
    end else begin
      if (load) begin
        out_valid <= !qstat.empty;
      end
      if (take) begin
        beat <= (head.start && beat != 2'd3) ? beat + 2'd1 : 2'd0;
      end
    end
  end

  // Load output payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte    <= byte_next;
      first       <= first_next;
      last        <= last_next;
      stream_code <= head.code;
      error       <= head.err && !head.start;
    end
  end

endmodule

// ===== hdl/mpeg_ps_packet_deframer_top.sv =====
// A byte accepted by the parser is written into the queue, then moved into the output
// register; a stalled output holds it in the queue. Throughput: one input byte per
// cycle while the queue is not full; one result per cycle while the output is not
// stalled. A start code yields four results from the single output register.
// A four-entry queue between parser and output lets each side stall on its own.
// Reset (synchronous, active high): queue empty, output invalid, parser hunting
// with the sync window all ones.
module mpeg_ps_packet_deframer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       first,
  output logic       last,
  output logic [7:0] stream_code,
  output logic       error
);

  mpd_pkg::entry_t push_entry;
  mpd_pkg::entry_t head;
  mpd_pkg::qstat_t qstat;
  logic            push;
  logic            pop;

  mpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  mpd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  mpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .first       (first),
    .last        (last),
    .stream_code (stream_code),
    .error       (error)
  );

endmodule

// ===== tb/sv/tb_mpeg_ps_packet_deframer_top.sv =====
`timescale 1ns / 1ps

module tb_mpeg_ps_packet_deframer_top;

  localparam int          CYCLE_LIMIT   = 100000;
  localparam logic [7:0]  CODE_VIDEO    = 8'hE0;
  localparam logic [7:0]  BAD_PACK_TYPE = 8'hC0;

  // One packet byte as it leaves the block
  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [7:0] code;
    logic       err;
  } pkt_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       first;
  logic       last;
  logic [7:0] stream_code;
  logic       error;

  // Stream bytes waiting to be sent and packet bytes waiting to come out
  logic [7:0] stream_q[$];
  pkt_out_t   out_bytes_due[$];

  int bytes_queued = 0;
  int bytes_taken = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Parser state of the predictor
  logic [23:0]      sync_win;
  mpd_pkg::phase_t  parse_ph;
  logic [3:0]       hdr_pos;
  logic [15:0]      body_left;
  logic [7:0]       pkt_code;
  logic             is_mpeg2;
  logic [2:0]       stuff_left;

  mpeg_ps_packet_deframer_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .first       (first),
    .last        (last),
    .stream_code (stream_code),
    .error       (error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue one expected packet byte, tagged with the current code
  function automatic void due(input logic [7:0] b, input logic f, input logic l,
                              input logic e);
    pkt_out_t r;
    r.data  = b;
    r.first = f;
    r.last  = l;
    r.code  = pkt_code;
    r.err   = e;
    out_bytes_due.push_back(r);
  endfunction

  // Close the packet and resume hunting with a fresh window
  function automatic void enter_hunt();
    parse_ph   = mpd_pkg::PH_HUNT;
    sync_win   = mpd_pkg::SYNC_ONES;
    hdr_pos    = 4'd0;
    body_left  = 16'd0;
    stuff_left = 3'd0;
  endfunction

  function automatic void reset_parser();
    enter_hunt();
    pkt_code = 8'h00;
    is_mpeg2 = 1'b0;
  endfunction

  // Advance the parser by one stream byte and queue what it emits
  function automatic void deframe_byte(input logic [7:0] b);
    logic pack2;
    logic pack1;
    pack2 = ((b & mpd_pkg::MPEG2_MASK) == mpd_pkg::MPEG2_MARK);
    pack1 = ((b & mpd_pkg::MPEG1_MASK) == mpd_pkg::MPEG1_MARK);
    case (parse_ph)
      mpd_pkg::PH_LEN: begin
        if (hdr_pos == 4'd4) begin
          if (pkt_code == mpd_pkg::CODE_PACK && !pack2 && !pack1) begin
            // unknown pack type: flag, close, hunt
            due(b, 1'b0, 1'b1, 1'b1);
            enter_hunt();
          end else begin
            hdr_pos = 4'd5;
            if (pkt_code == mpd_pkg::CODE_PACK) is_mpeg2 = pack2;
            else body_left = {b, 8'h00};
            due(b, 1'b0, 1'b0, 1'b0);
          end
        end else begin
          if (pkt_code == mpd_pkg::CODE_PACK) begin
            body_left = is_mpeg2 ? mpd_pkg::PACK2_BODY : mpd_pkg::PACK1_BODY;
          end else begin
            body_left[7:0] = b;
          end
          if (body_left == 16'd0) begin
            due(b, 1'b0, 1'b1, 1'b0);
            enter_hunt();
          end else begin
            parse_ph = mpd_pkg::PH_BODY;
            hdr_pos  = 4'd0;
            due(b, 1'b0, 1'b0, 1'b0);
          end
        end
      end
      mpd_pkg::PH_BODY: begin
        body_left = body_left - 16'd1;
        if (body_left != 16'd0) begin
          due(b, 1'b0, 1'b0, 1'b0);
        end else begin
          due(b, 1'b0, 1'b1, 1'b0);
          enter_hunt();
          // MPEG-2 pack header: low bits of its last byte count stuffing
          if (pkt_code == mpd_pkg::CODE_PACK && is_mpeg2 && b[2:0] != 3'd0) begin
            parse_ph   = mpd_pkg::PH_STUFF;
            stuff_left = b[2:0];
          end
        end
      end
      mpd_pkg::PH_STUFF: begin
        stuff_left = stuff_left - 3'd1;
        if (stuff_left == 3'd0) enter_hunt();
      end
      default: begin
        if (sync_win == mpd_pkg::SYNC_PREFIX) begin
          pkt_code = b;
          due(mpd_pkg::SYNC_PREFIX[23:16], 1'b1, 1'b0, 1'b0);
          due(mpd_pkg::SYNC_PREFIX[15:8], 1'b0, 1'b0, 1'b0);
          due(mpd_pkg::SYNC_PREFIX[7:0], 1'b0, 1'b0, 1'b0);
          if (b == mpd_pkg::CODE_END) begin
            due(b, 1'b0, 1'b1, 1'b0);
            enter_hunt();
          end else begin
            due(b, 1'b0, 1'b0, 1'b0);
            sync_win  = mpd_pkg::SYNC_ONES;
            parse_ph  = mpd_pkg::PH_LEN;
            hdr_pos   = 4'd4;
            body_left = 16'd0;
          end
        end else begin
          sync_win = {sync_win[15:0], b};
        end
      end
    endcase
  endfunction

  // Stream builders
  task automatic push_b(input logic [7:0] b);
    stream_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_start(input logic [7:0] c);
    push_b(mpd_pkg::SYNC_PREFIX[23:16]);
    push_b(mpd_pkg::SYNC_PREFIX[15:8]);
    push_b(mpd_pkg::SYNC_PREFIX[7:0]);
    push_b(c);
  endtask

  task automatic push_pes(input logic [7:0] c, input logic [15:0] len);
    push_start(c);
    push_b(len[15:8]);
    push_b(len[7:0]);
    for (int i = 0; i < len; i++) push_b(8'($urandom_range(255)));
  endtask

  task automatic push_pack(input logic mp2, input logic [2:0] nstuff);
    int nbody;
    nbody = mp2 ? int'(mpd_pkg::PACK2_BODY) : int'(mpd_pkg::PACK1_BODY);
    push_start(mpd_pkg::CODE_PACK);
    if (mp2) push_b({mpd_pkg::MPEG2_MARK[7:6], 6'($urandom_range(63))});
    else push_b({mpd_pkg::MPEG1_MARK[7:4], 4'($urandom_range(15))});
    push_b(8'($urandom_range(255)));
    for (int i = 0; i < nbody - 1; i++) push_b(8'($urandom_range(255)));
    if (mp2) push_b({5'($urandom_range(31)), nstuff});
    else push_b(8'($urandom_range(255)));
    for (int i = 0; i < nstuff; i++) push_b(8'($urandom_range(255)));
  endtask

  task automatic push_bad_pack();
    logic [7:0] t;
    t = 8'($urandom_range(255));
    while ((t & mpd_pkg::MPEG2_MASK) == mpd_pkg::MPEG2_MARK ||
           (t & mpd_pkg::MPEG1_MASK) == mpd_pkg::MPEG1_MARK)
      t = 8'($urandom_range(255));
    push_start(mpd_pkg::CODE_PACK);
    push_b(t);
  endtask

  // Mostly well-formed packets with random content, some noise in between
  task automatic gen_random(input int target);
    int         n;
    int         r;
    int         len;
    logic [7:0] c;
    n = 0;
    while (n < target) begin
      r = $urandom_range(99);
      if (r < 40) begin
        c = 8'($urandom_range(255));
        while (c == mpd_pkg::CODE_END || c == mpd_pkg::CODE_PACK)
          c = 8'($urandom_range(255));
        len = $urandom_range(12);
        push_pes(c, 16'(len));
        n += 6 + len;
      end else if (r < 58) begin
        push_pack(1'b1, 3'($urandom_range(7)));
        n += 14;
      end else if (r < 68) begin
        push_pack(1'b0, 3'd0);
        n += 12;
      end else if (r < 76) begin
        push_start(mpd_pkg::CODE_END);
        n += 4;
      end else if (r < 84) begin
        push_bad_pack();
        n += 5;
      end else begin
        // noise, sometimes a broken prefix or zero padding
        if ($urandom_range(1)) begin
          push_b(mpd_pkg::SYNC_PREFIX[23:16]);
          push_b(mpd_pkg::SYNC_PREFIX[15:8]);
        end
        repeat ($urandom_range(1, 4)) push_b(8'($urandom_range(255)));
        if ($urandom_range(3) == 0) push_b(8'h00);
      end
    end
  endtask

  // Hold the sender until every request is in and every result is out
  task automatic drain();
    while (bytes_taken != bytes_queued || out_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Driver: predict on acceptance, then present the next request or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_byte  <= stream_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expected byte
  always @(posedge clk) begin : monitor
    pkt_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (out_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %02h first %0b last %0b code %02h err %0b",
                     out_byte, first, last, stream_code, error);
        end else begin
          want = out_bytes_due.pop_front();
          if (out_byte !== want.data || first !== want.first || last !== want.last ||
              stream_code !== want.code || error !== want.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %02h f%0b l%0b c%02h e%0b, got %02h f%0b l%0b c%02h e%0b",
                       want.data, want.first, want.last, want.code, want.err,
                       out_byte, first, last, stream_code, error);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    reset_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 25;
    recv_stall_pct = 69;

    // Directed: padding and extremes, end code, zero length, bad pack type
    push_b(8'h00);
    push_b(8'hFF);
    push_start(mpd_pkg::CODE_END);
    push_pes(8'hFF, 16'd0);
    push_start(mpd_pkg::CODE_PACK);
    push_b(BAD_PACK_TYPE);
    push_pes(8'h00, 16'd1);

    gen_random(8);
    drain();

    send_idle_pct  = 69;
    recv_stall_pct = 25;
    gen_random(8);
    drain();

    // No idling; one packet long enough to use the length high byte
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_pes(CODE_VIDEO, 16'h0100 + 16'($urandom_range(3)));
    gen_random(4);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && out_bytes_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
